/* rtl/core/y2r_pkg.sv */
// Package with the fixed-point constants of the YUYV to RGBA conversion.
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

   localparam int COEF_FRAC_BITS = 16;

   localparam int PIXEL_W  = 8;
   localparam int OFFSET_W = PIXEL_W + 1;
   // Combined factors stay below 4.0, so two integer bits and a sign bit suffice.
   localparam int COEF_W   = COEF_FRAC_BITS + 3;
   localparam int ACC_W    = COEF_W + OFFSET_W + 2;

   localparam longint unsigned FULL_SCALE   = 255;
   localparam longint unsigned LUMA_SPAN    = 219;
   localparam longint unsigned CHROMA_SPAN  = 224;
   localparam longint unsigned MILLI        = 1000;
   localparam longint unsigned FACTOR_RV    = 1402;
   localparam longint unsigned FACTOR_GU    = 344;
   localparam longint unsigned FACTOR_GV    = 714;
   localparam longint unsigned FACTOR_BU    = 1772;
   localparam longint unsigned CHROMA_DEN   = CHROMA_SPAN * MILLI;

   localparam longint unsigned K_Y_VAL =
      ((FULL_SCALE << COEF_FRAC_BITS) + LUMA_SPAN / 2) / LUMA_SPAN;
   localparam longint unsigned K_RV_VAL =
      (((FACTOR_RV * FULL_SCALE) << COEF_FRAC_BITS) + CHROMA_DEN / 2) / CHROMA_DEN;
   localparam longint unsigned K_GU_VAL =
      (((FACTOR_GU * FULL_SCALE) << COEF_FRAC_BITS) + CHROMA_DEN / 2) / CHROMA_DEN;
   localparam longint unsigned K_GV_VAL =
      (((FACTOR_GV * FULL_SCALE) << COEF_FRAC_BITS) + CHROMA_DEN / 2) / CHROMA_DEN;
   localparam longint unsigned K_BU_VAL =
      (((FACTOR_BU * FULL_SCALE) << COEF_FRAC_BITS) + CHROMA_DEN / 2) / CHROMA_DEN;

   localparam logic signed [COEF_W-1:0] K_Y  = $signed(COEF_W'(K_Y_VAL));
   localparam logic signed [COEF_W-1:0] K_RV = $signed(COEF_W'(K_RV_VAL));
   localparam logic signed [COEF_W-1:0] K_GU = $signed(COEF_W'(K_GU_VAL));
   localparam logic signed [COEF_W-1:0] K_GV = $signed(COEF_W'(K_GV_VAL));
   localparam logic signed [COEF_W-1:0] K_BU = $signed(COEF_W'(K_BU_VAL));

   localparam logic signed [OFFSET_W-1:0] LUMA_OFFSET   = 9'sd16;
   localparam logic signed [OFFSET_W-1:0] CHROMA_OFFSET = 9'sd128;

   localparam logic [PIXEL_W-1:0] CHANNEL_MAX  = 8'd255;
   localparam logic [PIXEL_W-1:0] CHANNEL_MIN  = 8'd0;
   localparam logic [PIXEL_W-1:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

/* rtl/core/y2r_channel_if.sv */
// Stream interfaces for the macropixel input and the RGBA result channel.
`timescale 1ns / 1ps
`default_nettype none

interface y2r_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first;
   logic [7:0] chroma_blue;
   logic [7:0] luma_second;
   logic [7:0] chroma_red;

   modport source (output valid, output luma_first, output chroma_blue,
                   output luma_second, output chroma_red, input ready);
   modport sink   (input valid, input luma_first, input chroma_blue,
                   input luma_second, input chroma_red, output ready);
endinterface

interface y2r_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_first;
   logic [7:0] green_first;
   logic [7:0] blue_first;
   logic [7:0] red_second;
   logic [7:0] green_second;
   logic [7:0] blue_second;
   logic [7:0] alpha_both;

   modport source (output valid, output red_first, output green_first,
                   output blue_first, output red_second, output green_second,
                   output blue_second, output alpha_both, input ready);
   modport sink   (input valid, input red_first, input green_first,
                   input blue_first, input red_second, input green_second,
                   input blue_second, input alpha_both, output ready);
endinterface

`default_nettype wire

/* rtl/core/y2r_pixel_conv.sv */
// Combinational conversion of one luma sample and a shared chroma pair to RGB.
`timescale 1ns / 1ps
`default_nettype none

module y2r_pixel_conv (
   input  wire logic [y2r_pkg::PIXEL_W-1:0]          luma,
   input  wire logic signed [y2r_pkg::OFFSET_W-1:0]  chroma_u,
   input  wire logic signed [y2r_pkg::OFFSET_W-1:0]  chroma_v,
   output      y2r_pkg::rgb_type                     rgb
);
   import y2r_pkg::*;

   logic signed [OFFSET_W-1:0] luma_off;
   logic signed [ACC_W-1:0]    y_term;
   logic signed [ACC_W-1:0]    rv_term;
   logic signed [ACC_W-1:0]    gu_term;
   logic signed [ACC_W-1:0]    gv_term;
   logic signed [ACC_W-1:0]    bu_term;
   logic signed [ACC_W-1:0]    red_acc;
   logic signed [ACC_W-1:0]    green_acc;
   logic signed [ACC_W-1:0]    blue_acc;

   function automatic logic [PIXEL_W-1:0] floor_clamp(input logic signed [ACC_W-1:0] acc);
      logic [PIXEL_W-1:0] result;
      if (acc[ACC_W-1]) begin
         result = CHANNEL_MIN;
      end else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIXEL_W]) begin
         result = CHANNEL_MAX;
      end else begin
         result = acc[COEF_FRAC_BITS+PIXEL_W-1:COEF_FRAC_BITS];
      end
      return result;
   endfunction

   assign luma_off = $signed({1'b0, luma}) - LUMA_OFFSET;

   assign y_term  = ACC_W'(K_Y)  * ACC_W'(luma_off);
   assign rv_term = ACC_W'(K_RV) * ACC_W'(chroma_v);
   assign gu_term = ACC_W'(K_GU) * ACC_W'(chroma_u);
   assign gv_term = ACC_W'(K_GV) * ACC_W'(chroma_v);
   assign bu_term = ACC_W'(K_BU) * ACC_W'(chroma_u);

   assign red_acc   = y_term + rv_term;
   assign green_acc = y_term - gu_term - gv_term;
   assign blue_acc  = y_term + bu_term;

   assign rgb.red   = floor_clamp(red_acc);
   assign rgb.green = floor_clamp(green_acc);
   assign rgb.blue  = floor_clamp(blue_acc);

endmodule

`default_nettype wire

/* rtl/core/yuyv_to_rgba_converter_core.sv */
// YUYV macropixel to RGBA converter: BT.601 studio range, two pixels per transfer.
// An input transfer is captured in the input register, converted, and captured in the result register.
// Throughput: one macropixel per cycle while results are taken; the result register
// holds while the result side stalls, the input register holds once it is full as well,
// and ready passes back combinationally. Reset (synchronous, active high) empties both
// register stages; the conversion itself holds no state.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_rgba_converter_core (
   input  wire logic  clock,
   input  wire logic  reset,
   y2r_req_if.sink    req_channel,
   y2r_rsp_if.source  rsp_channel
);
   import y2r_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] luma_first_ff, luma_second_ff, chroma_blue_ff, chroma_red_ff;
   logic               out_valid_ff, out_valid_in;
   rgb_type            pixel_first_ff, pixel_second_ff;

   logic               out_load;
   logic               in_load;
   logic signed [OFFSET_W-1:0] chroma_u;
   logic signed [OFFSET_W-1:0] chroma_v;
   rgb_type            pixel_first;
   rgb_type            pixel_second;

   assign out_load = !out_valid_ff || rsp_channel.ready;
   assign in_load  = !in_valid_ff || out_load;
   assign req_channel.ready = in_load;

   assign in_valid_in  = in_load ? req_channel.valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_channel.valid) begin
         luma_first_ff  <= req_channel.luma_first;
         chroma_blue_ff <= req_channel.chroma_blue;
         luma_second_ff <= req_channel.luma_second;
         chroma_red_ff  <= req_channel.chroma_red;
      end
   end

   assign chroma_u = $signed({1'b0, chroma_blue_ff}) - CHROMA_OFFSET;
   assign chroma_v = $signed({1'b0, chroma_red_ff}) - CHROMA_OFFSET;

   y2r_pixel_conv u_conv_first (
      .luma     (luma_first_ff),
      .chroma_u (chroma_u),
      .chroma_v (chroma_v),
      .rgb      (pixel_first)
   );

   y2r_pixel_conv u_conv_second (
      .luma     (luma_second_ff),
      .chroma_u (chroma_u),
      .chroma_v (chroma_v),
      .rgb      (pixel_second)
   );

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         pixel_first_ff  <= pixel_first;
         pixel_second_ff <= pixel_second;
      end
   end

   assign rsp_channel.valid        = out_valid_ff;
   assign rsp_channel.red_first    = pixel_first_ff.red;
   assign rsp_channel.green_first  = pixel_first_ff.green;
   assign rsp_channel.blue_first   = pixel_first_ff.blue;
   assign rsp_channel.red_second   = pixel_second_ff.red;
   assign rsp_channel.green_second = pixel_second_ff.green;
   assign rsp_channel.blue_second  = pixel_second_ff.blue;
   assign rsp_channel.alpha_both   = ALPHA_OPAQUE;

endmodule

`default_nettype wire

/* rtl/core/y2r_checker.sv */
// Port-level checker for the YUYV to RGBA converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module y2r_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [47:0] rsp_pixels,
   input wire logic [7:0] rsp_alpha
);
   import y2r_pkg::*;

   logic [1:0] inflight_ff, inflight_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_xfer && !rsp_xfer) begin
         inflight_in = inflight_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         inflight_in = inflight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 2'd0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // A result is never shown without an item that produced it.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 2'd0 |-> !rsp_valid)
      else $error("result valid with no transfer in flight");

   // The two register stages hold at most two items.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff != 2'd3)
      else $error("more than two items in flight");

   // An empty pipeline always takes a new item.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 2'd0 |-> req_ready)
      else $error("input stalled while pipeline empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixels))
      else $error("stalled result changed");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha == ALPHA_OPAQUE)
      else $error("alpha not opaque");

endmodule

bind yuyv_to_rgba_converter_core y2r_checker u_y2r_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_channel.valid),
   .req_ready  (req_channel.ready),
   .rsp_valid  (rsp_channel.valid),
   .rsp_ready  (rsp_channel.ready),
   .rsp_pixels ({rsp_channel.red_first, rsp_channel.green_first, rsp_channel.blue_first,
                 rsp_channel.red_second, rsp_channel.green_second,
                 rsp_channel.blue_second}),
   .rsp_alpha  (rsp_channel.alpha_both)
);

`default_nettype wire

/* bench/tb_yuyv_to_rgba_converter_core.sv */
// Testbench for the YUYV to RGBA converter core: directed corners and random macropixels.
`timescale 1ns / 1ps

module tb_yuyv_to_rgba_converter_core;

   localparam int FRAC = y2r_pkg::COEF_FRAC_BITS;

   // Combined BT.601 studio-range factors, rounded to nearest in FRAC fraction bits.
   localparam longint COEF_Y  = ((longint'(255) << FRAC) + 109) / 219;
   localparam longint COEF_RV = ((longint'(1402 * 255) << FRAC) + 112000) / 224000;
   localparam longint COEF_GU = ((longint'(344 * 255) << FRAC) + 112000) / 224000;
   localparam longint COEF_GV = ((longint'(714 * 255) << FRAC) + 112000) / 224000;
   localparam longint COEF_BU = ((longint'(1772 * 255) << FRAC) + 112000) / 224000;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic [7:0] alpha_both;
   } rgba_pair_type;

   string field_name [7] = '{"red_first", "green_first", "blue_first", "red_second",
                             "green_second", "blue_second", "alpha_both"};

   logic clock;
   logic reset;

   y2r_req_if req_ch ();
   y2r_rsp_if rsp_ch ();

   yuyv_to_rgba_converter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   rgba_pair_type rgba_expected_q [$];
   int            error_count   = 0;
   int            req_gap_pct   = 0;
   int            rsp_stall_pct = 0;

   // ---------------------------------------------------------------- prediction

   function automatic logic [7:0] floor_to_byte(input longint sum);
      longint whole;
      if (sum < 0) return 8'd0;
      whole = sum >>> FRAC;
      return (whole > 255) ? 8'd255 : whole[7:0];
   endfunction

   function automatic logic [23:0] convert_pixel(input logic [7:0] luma,
                                                 input longint u, input longint v);
      longint luma_term;
      luma_term = COEF_Y * (longint'(luma) - 16);
      return {floor_to_byte(luma_term + COEF_RV * v),
              floor_to_byte(luma_term - COEF_GU * u - COEF_GV * v),
              floor_to_byte(luma_term + COEF_BU * u)};
   endfunction

   function automatic rgba_pair_type convert_macropixel(input logic [7:0] y0, cb, y1, cr);
      longint        u;
      longint        v;
      rgba_pair_type px;
      u = longint'(cb) - 128;
      v = longint'(cr) - 128;
      {px.red_first, px.green_first, px.blue_first}    = convert_pixel(y0, u, v);
      {px.red_second, px.green_second, px.blue_second} = convert_pixel(y1, u, v);
      px.alpha_both = 8'hFF;
      return px;
   endfunction

   // ---------------------------------------------------------------- clock and timeout

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- monitors

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         rgba_expected_q.push_back(convert_macropixel(req_ch.luma_first, req_ch.chroma_blue,
                                                      req_ch.luma_second, req_ch.chroma_red));
   end

   always @(posedge clock) begin
      rgba_pair_type expected;
      rgba_pair_type actual;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         actual = {rsp_ch.red_first, rsp_ch.green_first, rsp_ch.blue_first,
                   rsp_ch.red_second, rsp_ch.green_second, rsp_ch.blue_second,
                   rsp_ch.alpha_both};
         if (rgba_expected_q.size() == 0) begin
            $display("%0t: result transfer with nothing pending, got %h", $time, actual);
            error_count++;
         end else begin
            expected = rgba_expected_q.pop_front();
            for (int i = 0; i < 7; i++) begin
               if (expected[(6 - i) * 8 +: 8] !== actual[(6 - i) * 8 +: 8]) begin
                  $display("%0t: %s mismatch: expected %0d, actual %0d", $time,
                           field_name[i], expected[(6 - i) * 8 +: 8],
                           actual[(6 - i) * 8 +: 8]);
                  error_count++;
               end
            end
         end
      end
   end

   // The result side stalls in random bursts while rsp_stall_pct is nonzero.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_stall_pct != 0 && $urandom_range(99, 0) < rsp_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_macropixel(input logic [7:0] y0, cb, y1, cr);
      if (req_gap_pct != 0 && $urandom_range(99, 0) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.luma_first  <= y0;
      req_ch.chroma_blue <= cb;
      req_ch.luma_second <= y1;
      req_ch.chroma_red  <= cr;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Holds the input idle until every accepted macropixel has come back.
   // The first edge lets the monitor record the last transfer before the queue is polled.
   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rgba_expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_edge_byte();
      logic [7:0] edges [16] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129,
                                 8'd234, 8'd235, 8'd236, 8'd239, 8'd240, 8'd241,
                                 8'd254, 8'd255};
      if ($urandom_range(3, 0) == 0) return 8'($urandom());
      return edges[$urandom_range(15, 0)];
   endfunction

   // Field extremes, neutral chroma, the studio-range bounds and saturating colors.
   task automatic test_directed_corners();
      logic [31:0] corner_set [20] = '{
         32'h00_00_00_00, 32'hFF_FF_FF_FF, 32'h10_80_EB_80, 32'hEB_80_10_80,
         32'h10_10_EB_F0, 32'hEB_F0_10_10, 32'h00_80_FF_80, 32'h80_00_80_00,
         32'h80_FF_80_FF, 32'h00_00_FF_FF, 32'hFF_00_00_FF, 32'hFF_FF_00_00,
         32'h00_FF_FF_00, 32'h51_5A_91_F0, 32'h7E_80_7E_80, 32'h10_F0_10_F0,
         32'hEB_10_EB_10, 32'h01_7F_FE_81, 32'hAA_55_55_AA, 32'h55_AA_AA_55};
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      foreach (corner_set[i])
         send_macropixel(corner_set[i][31:24], corner_set[i][23:16],
                         corner_set[i][15:8], corner_set[i][7:0]);
   endtask

   task automatic test_random_full_range(input int count);
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      repeat (count)
         send_macropixel(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
   endtask

   task automatic test_random_studio_range(input int count);
      req_gap_pct   = 30;
      rsp_stall_pct = 10;
      repeat (count)
         send_macropixel(8'($urandom_range(235, 16)), 8'($urandom_range(240, 16)),
                         8'($urandom_range(235, 16)), 8'($urandom_range(240, 16)));
   endtask

   task automatic test_clamp_edges(input int count);
      req_gap_pct   = 10;
      rsp_stall_pct = 35;
      repeat (count)
         send_macropixel(pick_edge_byte(), pick_edge_byte(), pick_edge_byte(),
                         pick_edge_byte());
   endtask

   // Full rate on both sides to the end of the run.
   task automatic test_back_to_back(input int count);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      repeat (count)
         send_macropixel(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.luma_first  <= 8'd0;
      req_ch.chroma_blue <= 8'd0;
      req_ch.luma_second <= 8'd0;
      req_ch.chroma_red  <= 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      wait_all_results();
      test_random_full_range(550);
      test_random_studio_range(500);
      wait_all_results();
      test_clamp_edges(400);
      test_back_to_back(400);

      wait_all_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && rgba_expected_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
